// ----- rtl/slrm_pkg.sv -----
// Shared types, codes and reply tables for the serial logger reply matcher.
// No dependencies.
package slrm_pkg;

  typedef enum logic [2:0] {
    MODE_RESET_WAIT = 3'd0,
    MODE_READY      = 3'd1,
    MODE_ENTER_WAIT = 3'd2,
    MODE_CMD_READY  = 3'd3,
    MODE_CMD_WAIT   = 3'd4,
    MODE_RM_WAIT    = 3'd5,
    MODE_HALTED     = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    REQ_RX_BYTE   = 3'd0,
    REQ_RESET     = 3'd1,
    REQ_ENTER_CMD = 3'd2,
    REQ_CMD       = 3'd3,
    REQ_REMOVE    = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_RESET  = 3'd1,
    ERR_ENTER  = 3'd2,
    ERR_CMD    = 3'd3,
    ERR_REMOVE = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    LED_NONE   = 2'd0,
    LED_GREEN  = 2'd1,
    LED_ORANGE = 2'd2
  } led_t;

  localparam int ReqWidth  = 3;
  localparam int ByteWidth = 8;
  localparam int PosWidth  = 2;
  localparam int LenWidth  = 3;

  // Length of the expected reply for a waiting mode.
  function automatic logic [LenWidth-1:0] reply_len(input mode_t mode);
    logic [LenWidth-1:0] len;
    case (mode)
      MODE_RESET_WAIT: len = 3'd3;  // "12<"
      MODE_ENTER_WAIT: len = 3'd2;  // "~>"
      MODE_CMD_WAIT:   len = 3'd3;  // CR LF "<"
      MODE_RM_WAIT:    len = 3'd4;  // CR LF "!>"
      default:         len = 3'd1;
    endcase
    return len;
  endfunction

  // Expected byte at a position of the reply for a waiting mode.
  function automatic logic [ByteWidth-1:0] reply_char(input mode_t mode,
                                                      input logic [PosWidth-1:0] pos);
    logic [ByteWidth-1:0] ch;
    ch = 8'h00;
    case (mode)
      MODE_RESET_WAIT: begin
        case (pos)
          2'd0:    ch = 8'h31;  // '1'
          2'd1:    ch = 8'h32;  // '2'
          default: ch = 8'h3C;  // '<'
        endcase
      end
      MODE_ENTER_WAIT: begin
        case (pos)
          2'd0:    ch = 8'h7E;  // '~'
          default: ch = 8'h3E;  // '>'
        endcase
      end
      MODE_CMD_WAIT: begin
        case (pos)
          2'd0:    ch = 8'h0D;
          2'd1:    ch = 8'h0A;
          default: ch = 8'h3C;  // '<'
        endcase
      end
      MODE_RM_WAIT: begin
        case (pos)
          2'd0:    ch = 8'h0D;
          2'd1:    ch = 8'h0A;
          2'd2:    ch = 8'h21;  // '!'
          default: ch = 8'h3E;  // '>'
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/serial_logger_reply_matcher.sv -----
// Serial logger reply matcher: tracks link mode from command events and reply bytes.
// Depends on slrm_pkg (mode, request, error and LED codes, reply tables).
//
// Usage:
//   Slave stream: one beat per event. s_axis_tuser carries the request kind
//   (received byte or one of four commands), s_axis_tdata the received byte.
//   Master stream: exactly one beat per input beat, carrying the mode after
//   the event, the recorded error code and an LED event.
//   The mode registers update and the result register loads at the edge
//   that takes the input beat. Throughput is one beat per cycle while the
//   output drains; the single result register is the path's only storage.
//   When the receiver stalls, the held result blocks a new beat only if it
//   is still untaken; s_axis_tready = !m_axis_tvalid || m_axis_tready.
//   A reply mismatch sends the block into a sticky halted mode that only
//   rst leaves. Reset puts the link in reset-wait with no fault recorded
//   and the output empty.
module serial_logger_reply_matcher (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [2:0] s_axis_tuser,   // [2:0] req_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [2:0] mode_now, [5:3] error_code, [7:6] led_event
);

  slrm_pkg::mode_t                    link_mode, link_mode_next;
  logic [slrm_pkg::PosWidth-1:0]      match_position, match_position_next;
  slrm_pkg::err_t                     fault_code, fault_code_next;
  slrm_pkg::led_t                     led_next;

  logic                               in_beat;
  logic [slrm_pkg::LenWidth-1:0]      len;
  logic [slrm_pkg::PosWidth-1:0]      pos;
  logic [slrm_pkg::LenWidth-1:0]      pos_ext;
  logic [slrm_pkg::ByteWidth-1:0]     expect_byte;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Expected byte at the current (clamped) position.
  always_comb begin
    len = slrm_pkg::reply_len(link_mode);
    if ({1'b0, match_position} >= len) begin
      pos = slrm_pkg::PosWidth'(len - 3'd1);
    end else begin
      pos = match_position;
    end
    pos_ext     = {1'b0, pos};
    expect_byte = slrm_pkg::reply_char(link_mode, pos);
  end

  always_comb begin
    link_mode_next      = link_mode;
    match_position_next = match_position;
    fault_code_next     = fault_code;
    led_next            = slrm_pkg::LED_NONE;
    if (link_mode != slrm_pkg::MODE_HALTED) begin
      case (s_axis_tuser)
        slrm_pkg::REQ_RX_BYTE: begin
          if (link_mode == slrm_pkg::MODE_RESET_WAIT ||
              link_mode == slrm_pkg::MODE_ENTER_WAIT ||
              link_mode == slrm_pkg::MODE_CMD_WAIT ||
              link_mode == slrm_pkg::MODE_RM_WAIT) begin
            if (s_axis_tdata != expect_byte) begin
              link_mode_next = slrm_pkg::MODE_HALTED;
              case (link_mode)
                slrm_pkg::MODE_RESET_WAIT: fault_code_next = slrm_pkg::ERR_RESET;
                slrm_pkg::MODE_ENTER_WAIT: fault_code_next = slrm_pkg::ERR_ENTER;
                slrm_pkg::MODE_CMD_WAIT:   fault_code_next = slrm_pkg::ERR_CMD;
                default:                   fault_code_next = slrm_pkg::ERR_REMOVE;
              endcase
            end else if (pos_ext + 3'd1 < len) begin
              match_position_next = pos + 2'd1;
            end else begin
              case (link_mode)
                slrm_pkg::MODE_RESET_WAIT: begin
                  link_mode_next = slrm_pkg::MODE_READY;
                  led_next       = slrm_pkg::LED_GREEN;
                end
                slrm_pkg::MODE_ENTER_WAIT: begin
                  link_mode_next = slrm_pkg::MODE_CMD_READY;
                  led_next       = slrm_pkg::LED_ORANGE;
                end
                default: link_mode_next = slrm_pkg::MODE_READY;
              endcase
            end
          end
        end
        slrm_pkg::REQ_RESET: begin
          link_mode_next      = slrm_pkg::MODE_RESET_WAIT;
          match_position_next = '0;
        end
        slrm_pkg::REQ_ENTER_CMD: begin
          link_mode_next      = slrm_pkg::MODE_ENTER_WAIT;
          match_position_next = '0;
        end
        slrm_pkg::REQ_CMD: begin
          link_mode_next      = slrm_pkg::MODE_CMD_WAIT;
          match_position_next = '0;
        end
        slrm_pkg::REQ_REMOVE: begin
          link_mode_next      = slrm_pkg::MODE_RM_WAIT;
          match_position_next = '0;
        end
        default: ;  // unknown request: no change
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode      <= slrm_pkg::MODE_RESET_WAIT;
      match_position <= '0;
      fault_code     <= slrm_pkg::ERR_NONE;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (in_beat) begin
        link_mode      <= link_mode_next;
        match_position <= match_position_next;
        fault_code     <= fault_code_next;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_axis_tdata <= {led_next, fault_code_next, link_mode_next};
    end
  end

endmodule

// ----- dv/tb_serial_logger_reply_matcher.sv -----
`timescale 1ns / 100ps
// Self-checking bench for serial_logger_reply_matcher: drives request beats and
// compares every status beat against a tracker of link mode, match position and fault.
// Depends on rtl/slrm_pkg.sv and rtl/serial_logger_reply_matcher.sv.

typedef struct packed {
  slrm_pkg::mode_t mode;
  slrm_pkg::err_t  fault;
  slrm_pkg::led_t  led;
} link_status_t;

// Reply text the logger sends back for each waiting mode; empty otherwise.
function automatic string reply_text(input slrm_pkg::mode_t mode);
  string txt;
  case (mode)
    slrm_pkg::MODE_RESET_WAIT: txt = "12<";
    slrm_pkg::MODE_ENTER_WAIT: txt = "~>";
    slrm_pkg::MODE_CMD_WAIT:   txt = "\015\012<";
    slrm_pkg::MODE_RM_WAIT:    txt = "\015\012!>";
    default:                   txt = "";
  endcase
  return txt;
endfunction

function automatic slrm_pkg::mode_t cmd_mode(input logic [2:0] req);
  slrm_pkg::mode_t mode;
  case (req)
    slrm_pkg::REQ_RESET:     mode = slrm_pkg::MODE_RESET_WAIT;
    slrm_pkg::REQ_ENTER_CMD: mode = slrm_pkg::MODE_ENTER_WAIT;
    slrm_pkg::REQ_CMD:       mode = slrm_pkg::MODE_CMD_WAIT;
    default:                 mode = slrm_pkg::MODE_RM_WAIT;
  endcase
  return mode;
endfunction

class link_tracker;
  slrm_pkg::mode_t link_mode;
  logic [1:0]      match_pos;
  slrm_pkg::err_t  fault;
  link_status_t    status_due[$];
  int              errors;
  int              beats_in;
  int              checked;
  int              greens;
  int              oranges;

  function new();
    link_mode = slrm_pkg::MODE_RESET_WAIT;
    match_pos = '0;
    fault     = slrm_pkg::ERR_NONE;
    errors    = 0;
    beats_in  = 0;
    checked   = 0;
    greens    = 0;
    oranges   = 0;
  endfunction

  task report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function int pending();
    return status_due.size();
  endfunction

  // One reply byte against the text of the current waiting mode.
  function slrm_pkg::led_t take_byte(input logic [7:0] b, input slrm_pkg::mode_t done,
                                     input slrm_pkg::err_t err, input slrm_pkg::led_t led);
    string      txt;
    int         pos;
    logic [7:0] want;
    txt  = reply_text(link_mode);
    pos  = (match_pos >= txt.len()) ? txt.len() - 1 : match_pos;
    want = txt[pos];
    if (b != want) begin
      link_mode = slrm_pkg::MODE_HALTED;
      fault     = err;
      return slrm_pkg::LED_NONE;
    end
    if (pos + 1 < txt.len()) begin
      match_pos = 2'(pos + 1);
      return slrm_pkg::LED_NONE;
    end
    link_mode = done;
    return led;
  endfunction

  function link_status_t next_status(input logic [2:0] req, input logic [7:0] b);
    link_status_t st;
    st.led = slrm_pkg::LED_NONE;
    if (link_mode != slrm_pkg::MODE_HALTED) begin
      case (req)
        slrm_pkg::REQ_RX_BYTE: begin
          case (link_mode)
            slrm_pkg::MODE_RESET_WAIT:
              st.led = take_byte(b, slrm_pkg::MODE_READY, slrm_pkg::ERR_RESET,
                                 slrm_pkg::LED_GREEN);
            slrm_pkg::MODE_ENTER_WAIT:
              st.led = take_byte(b, slrm_pkg::MODE_CMD_READY, slrm_pkg::ERR_ENTER,
                                 slrm_pkg::LED_ORANGE);
            slrm_pkg::MODE_CMD_WAIT:
              st.led = take_byte(b, slrm_pkg::MODE_READY, slrm_pkg::ERR_CMD,
                                 slrm_pkg::LED_NONE);
            slrm_pkg::MODE_RM_WAIT:
              st.led = take_byte(b, slrm_pkg::MODE_READY, slrm_pkg::ERR_REMOVE,
                                 slrm_pkg::LED_NONE);
            default: ;  // ready modes drop bytes
          endcase
        end
        slrm_pkg::REQ_RESET, slrm_pkg::REQ_ENTER_CMD, slrm_pkg::REQ_CMD,
        slrm_pkg::REQ_REMOVE: begin
          link_mode = cmd_mode(req);
          match_pos = '0;
        end
        default: ;
      endcase
    end
    st.mode  = link_mode;
    st.fault = fault;
    return st;
  endfunction

  function void note_beat(input logic [2:0] req, input logic [7:0] b);
    status_due.push_back(next_status(req, b));
    beats_in++;
  endfunction

  task check_status(input logic [7:0] d);
    link_status_t exp;
    if (status_due.size() == 0) begin
      report($sformatf("status beat 0x%02h with nothing outstanding", d));
      return;
    end
    exp = status_due.pop_front();
    checked++;
    if (d[2:0] != exp.mode)
      report($sformatf("mode_now %0d, want %0d", d[2:0], exp.mode));
    if (d[5:3] != exp.fault)
      report($sformatf("error_code %0d, want %0d", d[5:3], exp.fault));
    if (d[7:6] != exp.led)
      report($sformatf("led_event %0d, want %0d", d[7:6], exp.led));
    if (exp.led == slrm_pkg::LED_GREEN) greens++;
    if (exp.led == slrm_pkg::LED_ORANGE) oranges++;
  endtask
endclass

module tb_serial_logger_reply_matcher;
  localparam int QuietLimit = 5000;
  localparam int UsefulItems = 1200;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] rx_byte
  logic [2:0] s_axis_tuser;   // [2:0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [2:0] mode_now, [5:3] error_code, [7:6] led_event

  link_tracker     trk = new();
  slrm_pkg::mode_t gen_mode;
  int              useful;
  bit              steady;
  int unsigned     quiet_cycles;

  serial_logger_reply_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 29);
  end

  // Beats are taken from pre-edge values; watchdog counts edges with no beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) trk.check_status(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) trk.note_beat(s_axis_tuser, s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no beat for %0d cycles", QuietLimit);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input logic [2:0] req, input logic [7:0] b, input bit counts);
    if (!steady) begin
      while ($urandom_range(99) < 29) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (counts) useful++;
  endtask

  task automatic issue_cmd(input logic [2:0] req);
    send_item(req, 8'($urandom), 1'b1);
    gen_mode = cmd_mode(req);
  endtask

  // Sends the first 'upto' bytes of the reply for the current waiting mode.
  task automatic feed_reply(input int upto, input bit sprinkle);
    string txt;
    int    k;
    txt = reply_text(gen_mode);
    for (k = 0; k < upto; k++) begin
      if (sprinkle && $urandom_range(9) == 0)
        send_item(3'($urandom_range(7, 5)), 8'($urandom), 1'b0);
      send_item(slrm_pkg::REQ_RX_BYTE, txt[k], 1'b1);
    end
    if (upto == txt.len()) begin
      if (gen_mode == slrm_pkg::MODE_ENTER_WAIT) gen_mode = slrm_pkg::MODE_CMD_READY;
      else gen_mode = slrm_pkg::MODE_READY;
    end
  endtask

  task automatic send_noise();
    int n;
    int k;
    n = $urandom_range(4, 1);
    for (k = 0; k < n; k++) begin
      if ((gen_mode == slrm_pkg::MODE_READY || gen_mode == slrm_pkg::MODE_CMD_READY) &&
          $urandom_range(3) != 0)
        send_item(slrm_pkg::REQ_RX_BYTE, 8'($urandom), 1'b0);
      else
        send_item(3'($urandom_range(7, 5)), 8'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (trk.pending() != 0) @(negedge clk);
  endtask

  initial begin
    string      txt;
    int         pick;
    int         cut;
    bit         drained;
    logic [2:0] req;
    logic [7:0] good;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    steady        = 1'b0;
    useful        = 0;
    quiet_cycles  = 0;
    drained       = 1'b0;
    gen_mode      = slrm_pkg::MODE_RESET_WAIT;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unknown request, the four replies, ready drops, interrupted replies.
    send_item(3'd7, 8'hA5, 1'b0);
    feed_reply(3, 1'b0);
    send_item(slrm_pkg::REQ_RX_BYTE, 8'hFF, 1'b0);
    send_item(slrm_pkg::REQ_RX_BYTE, 8'h00, 1'b0);
    issue_cmd(slrm_pkg::REQ_ENTER_CMD);
    feed_reply(2, 1'b0);
    send_item(3'd5, 8'h5A, 1'b0);
    issue_cmd(slrm_pkg::REQ_CMD);
    feed_reply(3, 1'b0);
    issue_cmd(slrm_pkg::REQ_REMOVE);
    feed_reply(4, 1'b0);
    issue_cmd(slrm_pkg::REQ_RESET);
    feed_reply(1, 1'b0);
    issue_cmd(slrm_pkg::REQ_ENTER_CMD);           // command mid-reply restarts the match
    send_item(slrm_pkg::REQ_RX_BYTE, 8'h7E, 1'b1);
    send_item(3'd6, 8'hC3, 1'b0);                 // unknown request keeps the position
    send_item(slrm_pkg::REQ_RX_BYTE, 8'h3E, 1'b1);
    gen_mode = slrm_pkg::MODE_CMD_READY;

    // Random: mostly complete replies, some cut short by a new command, some noise.
    while (useful < UsefulItems) begin
      steady = (useful >= 500 && useful < 800);
      if (!drained && useful >= 1000) begin
        wait_drained();
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        issue_cmd(3'($urandom_range(4, 1)));
        txt = reply_text(gen_mode);
        feed_reply(txt.len(), 1'b1);
      end else if (pick < 85) begin
        issue_cmd(3'($urandom_range(4, 1)));
        txt = reply_text(gen_mode);
        feed_reply($urandom_range(txt.len() - 1), 1'b1);
      end else begin
        send_noise();
      end
    end
    steady = 1'b0;

    // Close with one reply mismatch, then show that halted ignores everything.
    req = 3'($urandom_range(4, 1));
    issue_cmd(req);
    txt = reply_text(gen_mode);
    cut = $urandom_range(txt.len() - 1);
    feed_reply(cut, 1'b0);
    good = txt[cut];
    send_item(slrm_pkg::REQ_RX_BYTE, good ^ 8'($urandom_range(255, 1)), 1'b1);
    gen_mode = slrm_pkg::MODE_HALTED;
    repeat (8) send_item(3'($urandom_range(7)), 8'($urandom), 1'b0);
    send_item(slrm_pkg::REQ_RESET, 8'h00, 1'b0);
    send_item(slrm_pkg::REQ_RX_BYTE, 8'h31, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d request beats, %0d status beats checked, %0d green / %0d orange",
             trk.beats_in, trk.checked, trk.greens, trk.oranges);
    $display("link halted at the end with fault %s", trk.fault.name());
    if (trk.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- serial_logger_reply_matcher.f -----
rtl/slrm_pkg.sv
rtl/serial_logger_reply_matcher.sv
dv/tb_serial_logger_reply_matcher.sv
